[src/sosp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizes and codes for the set-of-stacks block.
// No dependencies; every other file imports this package.
package sosp_pkg;

    localparam int TOTAL_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int SIDX_W = 6;
    localparam int OCNT_W = 7;
    localparam int CAP_W  = 7;

    localparam int IDX_W  = $clog2(TOTAL_DEPTH);
    localparam int CNT_W  = $clog2(TOTAL_DEPTH + 1);
    localparam int CW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int PROD_W = SIDX_W + 1 + CW;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd4;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        S_RUN,
        S_RECALC
    } ctl_state_t;

    typedef struct packed {
        logic             load;
        logic             shift;
        logic [IDX_W-1:0] pos;
    } cell_ctl_t;

    typedef struct packed {
        status_t       status;
        logic          take;
        logic [CW-1:0] value_count;
        logic [CW-1:0] stack_count;
    } ctl_res_t;

endpackage

[src/sosp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command words in, result words out, capacity writes.
// Depends on sosp_pkg for field widths.
interface sosp_item_if;
    import sosp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] push_value;
    logic [SIDX_W-1:0] stack_index;

    modport source (output valid, command, push_value, stack_index, input ready);
    modport sink   (input valid, command, push_value, stack_index, output ready);
endinterface

interface sosp_result_if;
    import sosp_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] popped_value;
    logic [1:0]        status;
    logic [OCNT_W-1:0] value_count;
    logic [OCNT_W-1:0] stack_count;

    modport source (output valid, popped_value, status, value_count, stack_count,
                    input ready);
    modport sink   (input valid, popped_value, status, value_count, stack_count,
                    output ready);
endinterface

interface sosp_cfg_if;
    import sosp_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] stack_capacity;

    modport source (output valid, stack_capacity, input ready);
    modport sink   (input valid, stack_capacity, output ready);
endinterface

[src/sosp_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the value chain: loads a pushed word or takes its right neighbor.
// Depends on sosp_pkg.
module sosp_cell (
    input  logic                            clk,
    input  sosp_pkg::cell_ctl_t             ctl,
    input  logic [sosp_pkg::IDX_W-1:0]      my_idx,
    input  logic [sosp_pkg::VALUE_WIDTH-1:0] push_word,
    input  logic [sosp_pkg::VALUE_WIDTH-1:0] right_q,
    output logic [sosp_pkg::VALUE_WIDTH-1:0] q,
    output logic [sosp_pkg::VALUE_WIDTH-1:0] tap
);
    import sosp_pkg::*;

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.load && (ctl.pos == my_idx))
        begin
            val_next = push_word;
        end
        else if (ctl.shift && (my_idx >= ctl.pos))
        begin
            val_next = right_q;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q   = val_reg;
    assign tap = (ctl.pos == my_idx) ? val_reg : '0;

endmodule

[src/sosp_ctrl.sv]
`timescale 1ns / 1ps
// Count keeper: held count, stack count, last-stack fill, capacity and its re-derive sequencer.
// Depends on sosp_pkg.
module sosp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sosp_pkg::CAP_W-1:0]  cfg_data,
    input  logic                        go,
    input  logic [sosp_pkg::CMD_W-1:0]  command,
    input  logic [sosp_pkg::SIDX_W-1:0] stack_index,
    output sosp_pkg::cell_ctl_t         ctl,
    output sosp_pkg::ctl_res_t          res,
    output logic                        busy
);
    import sosp_pkg::*;

    ctl_state_t       state_reg;
    ctl_state_t       state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic [CW-1:0]    held_reg;
    logic [CW-1:0]    held_next;
    logic [CW-1:0]    stacks_reg;
    logic [CW-1:0]    stacks_next;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    rem_next;

    logic [CW-1:0]     cap;
    logic              full;
    logic              rem_fits;
    logic              recalc_step;
    logic [PROD_W-1:0] stack_end;
    logic [PROD_W-1:0] held_wide;
    logic [PROD_W-1:0] top_pos;
    logic              take;
    status_t           status;

    assign cap       = (cap_reg == '0) ? CW'(1) : CW'(cap_reg);
    assign full      = (held_reg >= CW'(TOTAL_DEPTH));
    assign rem_fits  = (rem_reg <= cap);
    assign held_wide = PROD_W'(held_reg);
    assign stack_end = (PROD_W'(stack_index) + PROD_W'(1)) * PROD_W'(cap);
    assign top_pos   = ((stack_end > held_wide) ? held_wide : stack_end) - PROD_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_RUN:
            begin
                if (cfg_we)
                begin
                    state_next = S_RECALC;
                end
            end
            S_RECALC:
            begin
                if (!cfg_we && rem_fits)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b0;
        recalc_step = 1'b0;
        unique case (state_reg)
            S_RUN:
            begin
                busy = 1'b0;
            end
            S_RECALC:
            begin
                busy        = 1'b1;
                recalc_step = !cfg_we;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        held_next   = held_reg;
        stacks_next = stacks_reg;
        fill_next   = fill_reg;
        rem_next    = rem_reg;
        cap_next    = cap_reg;
        ctl         = '0;
        take        = 1'b0;
        status      = ST_OK;

        if (go)
        begin
            unique case (command)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        ctl.load  = 1'b1;
                        ctl.pos   = IDX_W'(held_reg);
                        held_next = held_reg + CW'(1);
                        if (fill_reg == cap)
                        begin
                            stacks_next = stacks_reg + CW'(1);
                            fill_next   = CW'(1);
                        end
                        else
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                end
                CMD_POP:
                begin
                    if (held_reg == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        take    = 1'b1;
                        ctl.pos = IDX_W'(held_reg - CW'(1));
                    end
                end
                CMD_POP_AT:
                begin
                    if (CW'(stack_index) >= stacks_reg)
                    begin
                        status = ST_BADIDX;
                    end
                    else if (held_reg == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        take    = 1'b1;
                        ctl.pos = top_pos[IDX_W-1:0];
                    end
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end

        if (take)
        begin
            ctl.shift = 1'b1;
            held_next = held_reg - CW'(1);
            if (held_reg == CW'(1))
            begin
                stacks_next = CW'(1);
                fill_next   = '0;
            end
            else if (fill_reg == CW'(1))
            begin
                stacks_next = stacks_reg - CW'(1);
                fill_next   = cap;
            end
            else
            begin
                fill_next = fill_reg - CW'(1);
            end
        end

        // walk the held count down one stack per cycle while no capacity write is pending
        if (recalc_step)
        begin
            if (rem_fits)
            begin
                fill_next = rem_reg;
            end
            else
            begin
                rem_next    = rem_reg - cap;
                stacks_next = stacks_reg + CW'(1);
            end
        end

        if (cfg_we)
        begin
            cap_next    = cfg_data;
            rem_next    = held_reg;
            stacks_next = CW'(1);
        end
    end

    assign res.status      = status;
    assign res.take        = take;
    assign res.value_count = held_next;
    assign res.stack_count = stacks_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RUN;
            cap_reg    <= CAP_RESET;
            held_reg   <= '0;
            stacks_reg <= CW'(1);
            fill_reg   <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            held_reg   <= held_next;
            stacks_reg <= stacks_next;
            fill_reg   <= fill_next;
            rem_reg    <= rem_next;
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(TOTAL_DEPTH))
        else $error("held count beyond storage depth");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && held_reg == '0) |-> (stacks_reg == CW'(1) && fill_reg == '0))
        else $error("empty store with stray stack shape");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && held_reg != '0) |-> (fill_reg != '0 && fill_reg <= cap))
        else $error("last stack fill out of range");

    a_no_item_in_recalc: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> (state_reg == S_RUN))
        else $error("word taken while re-deriving stacks");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (go && command == CMD_PUSH && !full) |=> (held_reg == $past(held_reg) + CW'(1)))
        else $error("accepted push did not grow the store");

endmodule

[src/set_of_stacks_with_pop_at.sv]
`timescale 1ns / 1ps
// Set of stacks with pop at index: top level with the cell chain and result register.
// Depends on sosp_pkg, sosp_if, sosp_cell and sosp_ctrl.
//
// Usage:
//   item   : command words in (push, pop newest, pop top of a given stack).
//   result : one word out per command: popped value, status, value and stack counts.
//   cfg    : writes the stack capacity; write only while the block is idle.
// The result word is registered at the edge that takes the command. Throughput
// is one command per cycle while item.ready is high, since every cell of the chain
// loads or shifts from its neighbor in that same cycle; the stack bookkeeping and
// the (index+1)*capacity product for pop at index sit in front of that edge.
// After a capacity write the stack boundaries are re-derived by subtracting the
// capacity once per cycle while no further write arrives, so item.ready stays
// low until the last stack is found; cfg is always ready.
// Reset clears the counts (empty, one stack, capacity 4) and the result valid flag;
// stored values are not cleared and are never read before being written.
// When the receiver stalls, the result word holds and item.ready drops until it
// is taken; a new command is taken in the same cycle the held word leaves.
module set_of_stacks_with_pop_at (
    input  logic          clk,
    input  logic          rst_n,
    sosp_item_if.sink     item,
    sosp_result_if.source result,
    sosp_cfg_if.sink      cfg
);
    import sosp_pkg::*;

    cell_ctl_t              ctl;
    ctl_res_t               res;
    logic                   busy;
    logic                   go;
    logic [VALUE_WIDTH-1:0] push_word;
    logic [VALUE_WIDTH-1:0] q    [TOTAL_DEPTH];
    logic [VALUE_WIDTH-1:0] tap  [TOTAL_DEPTH];
    logic [VALUE_WIDTH-1:0] picked;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] popped_reg;
    logic [1:0]        status_reg;
    logic [OCNT_W-1:0] value_count_reg;
    logic [OCNT_W-1:0] stack_count_reg;

    assign item.ready = !busy && (!out_valid_reg || result.ready);
    assign go         = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign push_word  = VALUE_WIDTH'(item.push_value);

    sosp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.stack_capacity),
        .go          (go),
        .command     (item.command),
        .stack_index (item.stack_index),
        .ctl         (ctl),
        .res         (res),
        .busy        (busy)
    );

    for (genvar i = 0; i < TOTAL_DEPTH; i++)
    begin : g_cell
        sosp_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .my_idx    (IDX_W'(i)),
            .push_word (push_word),
            .right_q   (q[(i + 1 < TOTAL_DEPTH) ? i + 1 : i]),
            .q         (q[i]),
            .tap       (tap[i])
        );
    end

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < TOTAL_DEPTH; i++)
        begin
            picked = picked | tap[i];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            popped_reg      <= res.take ? DATA_W'($signed(picked)) : '0;
            status_reg      <= res.status;
            value_count_reg <= OCNT_W'(res.value_count);
            stack_count_reg <= OCNT_W'(res.stack_count);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.popped_value = popped_reg;
    assign result.status       = status_reg;
    assign result.value_count  = value_count_reg;
    assign result.stack_count  = stack_count_reg;

endmodule

[tb/tb_set_of_stacks_with_pop_at.sv]
`timescale 1ns / 1ps
// Self-checking bench for the set-of-stacks block: directed table, then random phases.
// Depends on sosp_pkg, the sosp_if channel interfaces and set_of_stacks_with_pop_at.
module tb_set_of_stacks_with_pop_at;
    import sosp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int RANDOM_WORDS = 1650;
    localparam int DIRECTED_ROWS = 31;

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        status_t           status;
        logic [OCNT_W-1:0] vcount;
        logic [OCNT_W-1:0] scount;
    } stack_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic [SIDX_W-1:0] idx;
        logic [7:0]        reps;
        logic              rand_val;
        logic              typed;
        stack_result_t     res;
    } plan_row_t;

    localparam stack_result_t NO_RES = '0;

    logic clk;
    logic rst_n;

    sosp_item_if   item_bus ();
    sosp_result_if result_bus ();
    sosp_cfg_if    cap_bus ();

    set_of_stacks_with_pop_at dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cap_bus)
    );

    // shadow copy of the stacks
    logic [DATA_W-1:0] shelf [TOTAL_DEPTH];
    int                held;
    int                stacks;
    int                cap_reg;
    int                peak_held;

    stack_result_t pending [$];
    int            fault_count;
    int            words_sent;
    int            results_seen;
    int            cap_writes;
    int            status_hits [4];
    int            calm_left;

    plan_row_t plan [DIRECTED_ROWS] = '{
        '{ROW_ITEM, CMD_POP,    32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_EMPTY, 7'd0, 7'd1}},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_EMPTY, 7'd0, 7'd1}},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd1,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_BADIDX, 7'd0, 7'd1}},
        '{ROW_ITEM, CMD_NOP,    32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd0, 7'd1}},
        '{ROW_ITEM, CMD_PUSH,   32'h7FFFFFFF, 6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd1, 7'd1}},
        '{ROW_ITEM, CMD_PUSH,   32'h80000000, 6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd2, 7'd1}},
        '{ROW_ITEM, CMD_PUSH,   32'hFFFFFFFF, 6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd3, 7'd1}},
        '{ROW_ITEM, CMD_PUSH,   32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd4, 7'd1}},
        '{ROW_ITEM, CMD_PUSH,   32'h5,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd5, 7'd2}},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd63, 8'd1,  1'b0, 1'b1,
          '{32'h0, ST_BADIDX, 7'd5, 7'd2}},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_OK, 7'd4, 7'd1}},
        '{ROW_ITEM, CMD_POP,    32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h5, ST_OK, 7'd3, 7'd1}},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'hFFFFFFFF, ST_OK, 7'd2, 7'd1}},
        '{ROW_ITEM, CMD_POP,    32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h80000000, ST_OK, 7'd1, 7'd1}},
        '{ROW_ITEM, CMD_POP,    32'h0,        6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h7FFFFFFF, ST_OK, 7'd0, 7'd1}},
        '{ROW_ITEM, CMD_PUSH,   32'h0,        6'd0,  8'd64, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_PUSH,   32'h1234,     6'd0,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_FULL, 7'd64, 7'd16}},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd15, 8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd16, 8'd1,  1'b0, 1'b1,
          '{32'h0, ST_BADIDX, 7'd63, 7'd16}},
        '{ROW_CFG,  CMD_NOP,    32'd1,        6'd0,  8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd62, 8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd0,  8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_PUSH,   32'h0,        6'd0,  8'd3,  1'b1, 1'b0, NO_RES},
        '{ROW_CFG,  CMD_NOP,    32'd64,       6'd0,  8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd0,  8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd1,  8'd1,  1'b0, 1'b1,
          '{32'h0, ST_BADIDX, 7'd63, 7'd1}},
        '{ROW_CFG,  CMD_NOP,    32'd0,        6'd0,  8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP_AT, 32'h0,        6'd62, 8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CMD_NOP,    32'd127,      6'd0,  8'd1,  1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CMD_POP,    32'h0,        6'd0,  8'd64, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CMD_NOP,    32'd4,        6'd0,  8'd1,  1'b0, 1'b0, NO_RES}
    };

    function automatic int cap_eff();
        return (cap_reg == 0) ? 1 : cap_reg;
    endfunction

    function automatic void rederive_stacks();
        stacks = (held == 0) ? 1 : (held + cap_eff() - 1) / cap_eff();
    endfunction

    function automatic stack_result_t run_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [DATA_W-1:0] val,
                                                  input logic [SIDX_W-1:0] idx);
        stack_result_t r;
        int            pos;
        int            lim;
        bit            take;
        r      = '0;
        r.status = ST_OK;
        take   = 1'b0;
        pos    = 0;
        case (cmd)
            CMD_PUSH:
            begin
                if (held >= TOTAL_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shelf[held] = val;
                    held++;
                end
            end
            CMD_POP:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos  = held - 1;
                    take = 1'b1;
                end
            end
            CMD_POP_AT:
            begin
                if (int'(idx) >= stacks)
                    r.status = ST_BADIDX;
                else if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    lim = (int'(idx) + 1) * cap_eff();
                    if (lim > held)
                        lim = held;
                    pos  = lim - 1;
                    take = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (take)
        begin
            r.popped = shelf[pos];
            for (int i = pos; i + 1 < held; i++)
                shelf[i] = shelf[i + 1];
            held--;
        end
        rederive_stacks();
        if (held > peak_held)
            peak_held = held;
        r.vcount = held[OCNT_W-1:0];
        r.scount = stacks[OCNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(40, 200);
            return 0;
        end
        if (r < 5)
            return $urandom_range(8, 40);
        if (r < 35)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3:       return 32'hFFFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            4:       return 7'($urandom_range(65, 126));
            5:       return 7'($urandom_range(17, 63));
            default: return 7'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic flag_fault(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at %0t on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                             input logic [SIDX_W-1:0] idx, input bit typed,
                             input stack_result_t typed_res);
        stack_result_t want;
        int            gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_bus.valid       <= 1'b1;
        item_bus.command     <= cmd;
        item_bus.push_value  <= val;
        item_bus.stack_index <= idx;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        want = run_command(cmd, val, idx);
        if (typed)
            want = typed_res;
        pending.insert(pending.size(), want);
        status_hits[want.status]++;
        words_sent++;
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        @(negedge clk);
        cap_bus.valid          <= 1'b1;
        cap_bus.stack_capacity <= value;
        @(posedge clk);
        while (!cap_bus.ready)
            @(posedge clk);
        cap_reg = value;
        rederive_stacks();
        cap_writes++;
        @(negedge clk);
        cap_bus.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, short mostly, with quiet stretches
    initial
    begin : result_stalls
        int hold;
        int quiet;
        int r;
        hold  = 0;
        quiet = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet > 0)
                quiet--;
            else if (hold == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    quiet = $urandom_range(50, 300);
                else if (r < 6)
                    hold = $urandom_range(8, 30);
                else if (r < 30)
                    hold = $urandom_range(1, 3);
            end
            if (hold > 0)
            begin
                hold--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        stack_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            results_seen++;
            if (pending.size() == 0)
                flag_fault("unexpected result", result_bus.popped_value, 32'h0);
            else
            begin
                want = pending[0];
                pending.delete(0);
                if (result_bus.popped_value !== want.popped)
                    flag_fault("popped_value", result_bus.popped_value, want.popped);
                if (result_bus.status !== want.status)
                    flag_fault("status", 32'(result_bus.status), 32'(want.status));
                if (result_bus.value_count !== want.vcount)
                    flag_fault("value_count", 32'(result_bus.value_count), 32'(want.vcount));
                if (result_bus.stack_count !== want.scount)
                    flag_fault("stack_count", 32'(result_bus.stack_count), 32'(want.scount));
            end
        end
    end

    initial
    begin : stimulus
        int               random_sent;
        int               phase_len;
        int               push_pct;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [SIDX_W-1:0] idx;

        rst_n                  = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.command       = CMD_NOP;
        item_bus.push_value    = '0;
        item_bus.stack_index   = '0;
        cap_bus.valid          = 1'b0;
        cap_bus.stack_capacity = CAP_RESET;
        held                   = 0;
        cap_reg                = int'(CAP_RESET);
        peak_held              = 0;
        fault_count            = 0;
        words_sent             = 0;
        results_seen           = 0;
        cap_writes             = 0;
        calm_left              = 0;
        random_sent            = 0;
        foreach (status_hits[s])
            status_hits[s] = 0;
        rederive_stacks();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            if (plan[k].kind == ROW_CFG)
                write_capacity(plan[k].val[CAP_W-1:0]);
            else
                for (int n = 0; n < int'(plan[k].reps); n++)
                    send_word(plan[k].cmd, plan[k].rand_val ? pick_value() : plan[k].val,
                              plan[k].idx, plan[k].typed, plan[k].res);
        end

        while (random_sent < RANDOM_WORDS)
        begin
            write_capacity(pick_capacity());
            phase_len = $urandom_range(60, 200);
            case ($urandom_range(0, 2))
                0:       push_pct = 25;
                1:       push_pct = 50;
                default: push_pct = 72;
            endcase
            for (int n = 0; n < phase_len && random_sent < RANDOM_WORDS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    cmd = CMD_NOP;
                else if (r < 2 + push_pct)
                    cmd = CMD_PUSH;
                else if ($urandom_range(0, 9) < 4)
                    cmd = CMD_POP;
                else
                    cmd = CMD_POP_AT;
                if ($urandom_range(0, 9) < 8)
                    idx = SIDX_W'($urandom_range(0, stacks - 1));
                else
                    idx = SIDX_W'($urandom_range(0, 63));
                send_word(cmd, pick_value(), idx, 1'b0, NO_RES);
                random_sent++;
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (pending.size() != 0)
            flag_fault("results left over", 32'(pending.size()), 32'h0);

        $display("%0d command words, %0d results, %0d capacity writes, peak fill %0d",
                 words_sent, results_seen, cap_writes, peak_held);
        $display("status mix: ok %0d, empty %0d, bad index %0d, full %0d; faults %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BADIDX],
                 status_hits[ST_FULL], fault_count);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
src/sosp_pkg.sv
src/sosp_if.sv
src/sosp_cell.sv
src/sosp_ctrl.sv
src/set_of_stacks_with_pop_at.sv
tb/tb_set_of_stacks_with_pop_at.sv
